// ----- rtl/fla_pkg.sv -----
// Shared constants and codes for the free-list slot allocator.
package fla_pkg;

  localparam int unsigned SLOTS_DEFAULT = 256;

  // Fixed field widths of the item payloads.
  localparam int unsigned OP_W    = 1;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 9;

  // Operation codes carried on in_tuser.
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  // Status codes carried on out_tuser.
  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_BAD_FREE = 2'd2;

endpackage

// ----- rtl/fla_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module fla_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = fla_pkg::SLOTS_DEFAULT
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- rtl/free_list_slot_allocator_top.sv -----
// Top level of the free-list slot allocator: controller, head, count and both memories.
//
// The allocator hands out slots of a fixed pool through a last-in-first-out
// free list. An item with in_tuser at the allocate code pops the head slot and
// returns it in granted_slot; an item with the free code pushes slot_to_free
// back at the head. A free of a slot that is out of range or not currently
// allocated reports an invalid free and changes nothing, and an allocate on an
// exhausted pool reports an empty pool. Every result carries the number of
// allocated slots after the item. For each item the link and allocated-flag
// memories are read first; then the head, the count and both memories are
// updated and the result is loaded into the output register. The update waits
// while a waiting result is not taken. Items are processed one at a time. No
// clearing pass is needed after reset: a fill mark records how many slots have
// ever been handed out, and memory entries at or above it read as their reset
// values, so the block can accept an item as soon as reset is released.
module free_list_slot_allocator_top #(
  parameter int unsigned SLOTS = fla_pkg::SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] slot_to_free
  input  logic        in_tuser,   // [0] op
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] granted_slot, [16:8] in_use_count, rest zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  // Link values range over 0..SLOTS, where SLOTS is the end-of-list marker.
  localparam int unsigned LW = $clog2(SLOTS + 1);
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SW = fla_pkg::SLOT_W;
  localparam int unsigned CW = fla_pkg::COUNT_W;
  localparam logic [LW-1:0] END_MARK = LW'(SLOTS);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r, state_nxt;

  logic [LW-1:0] head_r, head_nxt;
  logic [LW-1:0] count_r, count_nxt;
  logic [LW-1:0] fill_r, fill_nxt;     // slots at or above this were never handed out
  logic          op_r, op_nxt;
  logic [SW-1:0] slot_r, slot_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [SW-1:0] out_grant_r, out_grant_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;

  // Memory ports.
  logic          link_we, flag_we, mem_re;
  logic [IW-1:0] link_waddr, flag_waddr, flag_raddr;
  logic [LW-1:0] link_wdata, link_q;
  logic          flag_wdata, flag_q;

  // Widened views used for range checks and field truncation.
  logic [LW+SW-1:0] slot_wide, in_slot_wide, fill_wide, head_wide, count_wide;
  logic [LW-1:0]    slot_link;
  logic [LW-1:0]    link_eff;
  logic             flag_eff;
  logic             empty, slot_in_range, commit;

  assign in_slot_wide = {{LW{1'b0}}, in_tdata};
  assign slot_wide    = {{LW{1'b0}}, slot_r};
  assign fill_wide    = {{SW{1'b0}}, fill_r};
  assign head_wide    = {{SW{1'b0}}, head_r};
  assign count_wide   = {{SW{1'b0}}, count_nxt};
  assign slot_link    = slot_wide[LW-1:0];

  assign empty         = (head_r == END_MARK);
  assign slot_in_range = (slot_wide < (LW + SW)'(SLOTS));

  // Entries the fill mark has not yet reached still hold their reset contents:
  // the link points at the next slot and the slot is not allocated.
  assign link_eff = (head_r >= fill_r) ? head_r + LW'(1) : link_q;
  assign flag_eff = (slot_wide < fill_wide) ? flag_q : 1'b0;

  // Reads are issued in the accept cycle; the registered data is consumed in the execute state.
  assign mem_re     = in_tvalid && in_tready;
  assign flag_raddr = in_slot_wide[IW-1:0];

  fla_ram #(
    .WIDTH (LW),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (mem_re),
    .raddr (head_r[IW-1:0]),
    .rdata (link_q)
  );

  fla_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .re    (mem_re),
    .raddr (flag_raddr),
    .rdata (flag_q)
  );

  // The execute cycle completes once the output register is free to take the result.
  assign commit = (state_r == ST_EXEC) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    fill_nxt       = fill_r;
    op_nxt         = op_r;
    slot_nxt       = slot_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_grant_nxt  = out_grant_r;
    out_count_nxt  = out_count_r;
    link_we        = 1'b0;
    flag_we        = 1'b0;
    link_waddr     = head_r[IW-1:0];
    flag_waddr     = head_r[IW-1:0];
    link_wdata     = END_MARK;
    flag_wdata     = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          slot_nxt  = in_tdata;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          out_grant_nxt = '0;
          if (op_r == fla_pkg::OP_ALLOC) begin
            if (empty) begin
              out_status_nxt = fla_pkg::STATUS_EMPTY;
            end else begin
              out_status_nxt = fla_pkg::STATUS_OK;
              out_grant_nxt  = head_wide[SW-1:0];
              head_nxt       = link_eff;
              count_nxt      = count_r + LW'(1);
              link_we        = 1'b1;
              flag_we        = 1'b1;
              if (head_r >= fill_r) begin
                fill_nxt = head_r + LW'(1);
              end
            end
          end else begin
            if (!slot_in_range || !flag_eff) begin
              out_status_nxt = fla_pkg::STATUS_BAD_FREE;
            end else begin
              out_status_nxt = fla_pkg::STATUS_OK;
              link_we        = 1'b1;
              flag_we        = 1'b1;
              link_waddr     = slot_link[IW-1:0];
              flag_waddr     = slot_link[IW-1:0];
              link_wdata     = head_r;
              flag_wdata     = 1'b0;
              head_nxt       = slot_link;
              count_nxt      = count_r - LW'(1);
            end
          end
          out_count_nxt = count_wide[CW-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    slot_r       <= slot_nxt;
    out_status_r <= out_status_nxt;
    out_grant_r  <= out_grant_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, out_count_r, out_grant_r};

endmodule

// ----- rtl/fla_checker.sv -----
// Port-level checks for the free-list slot allocator, bound to the top level.
module fla_checker #(
  parameter int unsigned SLOTS = fla_pkg::SLOTS_DEFAULT
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  localparam int unsigned CW = fla_pkg::COUNT_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(SLOTS);

  // Only a successful allocate returns a non-zero slot.
  a_grant_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != fla_pkg::STATUS_OK) |-> (out_tdata[7:0] == 8'd0))
    else $error("slot granted on a failed item");

  // An empty pool means every slot is allocated.
  a_empty_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == fla_pkg::STATUS_EMPTY) |-> (out_tdata[16:8] == FULL_COUNT))
    else $error("pool reported empty while slots remain");

  // Items are processed one at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while one is in progress");

  // A result that is held back keeps its value.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind free_list_slot_allocator_top fla_checker #(.SLOTS(SLOTS)) u_fla_checker (.*);
